// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file of the stack pool block.
// Each macro expects signals named clk and rst_n in the calling scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SBMS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SBMS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/sbms_pkg.sv =====
// Package for the shared-buffer multi-stack block: widths, codes and item types.
// No dependencies; imported by every RTL file of the block.
`timescale 1ns / 1ps

package sbms_pkg;

    localparam int VALUE_W     = 32;
    localparam int SID_W       = 2;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // operation input codes
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    // command after classification by the front part
    typedef enum logic [1:0] {
        CMD_PUSH,
        CMD_POP,
        CMD_PUSH_REJECT,
        CMD_POP_REJECT
    } cmd_t;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        BS_IDLE,
        BS_LINK,
        BS_EXEC
    } back_state_t;

    typedef struct packed {
        cmd_t               cmd;
        logic [SID_W-1:0]   sid;
        logic [VALUE_W-1:0] value;
    } item_t;

    // one beat offered between two parts
    typedef struct packed {
        logic  valid;
        item_t item;
    } beat_t;

endpackage

// ===== rtl/sbms_front.sv =====
// Front part: takes command beats, classifies them and holds one for the queue.
// Depends on sbms_pkg.
`timescale 1ns / 1ps

module sbms_front #(
    parameter int NUM_STACKS = 4
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          operation,
    input  logic [sbms_pkg::SID_W-1:0]    stack_id,
    input  logic signed [sbms_pkg::VALUE_W-1:0] push_value,
    output sbms_pkg::beat_t               out_beat,
    input  logic                          out_ready
);
    import sbms_pkg::*;

    logic  vld_reg;
    logic  vld_next;
    item_t item_reg;
    item_t item_next;
    logic  valid_stack;
    logic  take;
    cmd_t  cmd;

    always_comb
    begin
        valid_stack = (int'(stack_id) < NUM_STACKS);
        if (operation == OP_PUSH)
        begin
            cmd = valid_stack ? CMD_PUSH : CMD_PUSH_REJECT;
        end
        else
        begin
            cmd = valid_stack ? CMD_POP : CMD_POP_REJECT;
        end
    end

    assign busy = vld_reg && !out_ready;
    assign take = start && !busy;

    always_comb
    begin
        vld_next  = take ? 1'b1 : (vld_reg && !out_ready);
        item_next = item_reg;
        if (take)
        begin
            item_next.cmd   = cmd;
            item_next.sid   = stack_id;
            item_next.value = push_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

    assign out_beat.valid = vld_reg;
    assign out_beat.item  = item_reg;

endmodule

// ===== rtl/sbms_queue.sv =====
// Short command queue between the front and back parts.
// Depends on sbms_pkg.
`timescale 1ns / 1ps

module sbms_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  sbms_pkg::beat_t in_beat,
    output logic            in_ready,
    output sbms_pkg::beat_t out_beat,
    input  logic            out_take
);
    import sbms_pkg::*;

    item_t             entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QPTR_W:0]   count_reg;
    logic [QPTR_W:0]   count_next;
    logic              push;
    logic              pop;

    assign in_ready = (count_reg != (QPTR_W + 1)'(QUEUE_DEPTH));
    assign push     = in_beat.valid && in_ready;
    assign pop      = out_take && (count_reg != '0);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= in_beat.item;
        end
    end

    assign out_beat.valid = (count_reg != '0);
    assign out_beat.item  = entry_reg[rd_ptr_reg];

endmodule

// ===== rtl/sbms_back.sv =====
// Back part: slot, link and head memories, free list and result register.
// Depends on sbms_pkg.
`timescale 1ns / 1ps

module sbms_back #(
    parameter int NUM_STACKS = 4,
    parameter int NUM_SLOTS  = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  sbms_pkg::beat_t                     in_beat,
    output logic                                in_take,
    output logic                                done,
    output logic signed [sbms_pkg::VALUE_W-1:0] pop_value,
    output logic [1:0]                          status,
    output logic                                pool_full,
    output logic                                stack_empty
);
    import sbms_pkg::*;

    localparam int SW = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
    localparam int IW = $clog2(NUM_SLOTS);
    localparam int LW = $clog2(NUM_SLOTS + 1);
    localparam logic [LW-1:0] LINK_NULL = LW'(NUM_SLOTS);

    logic [VALUE_W-1:0] values_mem [NUM_SLOTS];
    logic [LW-1:0]      links_mem  [NUM_SLOTS];
    logic [LW-1:0]      heads_mem  [NUM_STACKS];

    back_state_t        state_reg;
    back_state_t        state_next;
    item_t              cur_reg;
    item_t              cur_next;
    logic [LW-1:0]      free_head_reg;
    logic [LW-1:0]      free_head_next;
    logic [LW-1:0]      wm_reg;          // slots at or above this were never taken
    logic [LW-1:0]      wm_next;
    logic [NUM_STACKS-1:0] head_vld_reg;
    logic [NUM_STACKS-1:0] head_vld_next;
    logic [LW-1:0]      head_rd_reg;
    logic               head_rd_vld_reg;
    logic [LW-1:0]      link_rd_reg;
    logic [VALUE_W-1:0] value_rd_reg;

    logic               done_reg;
    logic               done_next;
    logic [VALUE_W-1:0] pop_value_reg;
    logic [VALUE_W-1:0] pop_value_next;
    status_t            status_reg;
    status_t            status_next;
    logic               pool_full_reg;
    logic               pool_full_next;
    logic               stack_empty_reg;
    logic               stack_empty_next;

    logic [LW-1:0]      head_eff;
    logic               head_null;
    logic               free_null;
    logic [SW-1:0]      head_raddr;
    logic [SW-1:0]      cur_sid;
    logic [IW-1:0]      link_raddr;
    logic [IW-1:0]      value_raddr;
    logic               head_we;
    logic [LW-1:0]      head_wdata;
    logic               link_we;
    logic [IW-1:0]      link_waddr;
    logic [LW-1:0]      link_wdata;
    logic               value_we;
    logic [LW-1:0]      next_free;

    assign head_eff    = head_rd_vld_reg ? head_rd_reg : LINK_NULL;
    assign head_null   = (head_eff >= LINK_NULL);
    assign free_null   = (free_head_reg >= LINK_NULL);
    assign head_raddr  = SW'(in_beat.item.sid);
    assign cur_sid     = SW'(cur_reg.sid);
    assign link_raddr  = (state_reg == BS_IDLE) ? IW'(free_head_reg) : IW'(head_eff);
    assign value_raddr = IW'(head_eff);

    always_comb
    begin
        state_next       = state_reg;
        in_take          = 1'b0;
        cur_next         = cur_reg;
        free_head_next   = free_head_reg;
        wm_next          = wm_reg;
        head_vld_next    = head_vld_reg;
        head_we          = 1'b0;
        head_wdata       = free_head_reg;
        link_we          = 1'b0;
        link_waddr       = IW'(free_head_reg);
        link_wdata       = head_eff;
        value_we         = 1'b0;
        next_free        = link_rd_reg;
        done_next        = 1'b0;
        pop_value_next   = '0;
        status_next      = ST_DONE;
        pool_full_next   = free_null;
        stack_empty_next = 1'b1;

        case (state_reg)
            BS_IDLE:
            begin
                if (in_beat.valid)
                begin
                    in_take    = 1'b1;
                    cur_next   = in_beat.item;
                    state_next = (in_beat.item.cmd == CMD_POP) ? BS_LINK : BS_EXEC;
                end
            end
            BS_LINK:
            begin
                state_next = BS_EXEC;
            end
            BS_EXEC:
            begin
                state_next = BS_IDLE;
                done_next  = 1'b1;
                case (cur_reg.cmd)
                    CMD_PUSH:
                    begin
                        if (free_null)
                        begin
                            status_next      = ST_OVERFLOW;
                            stack_empty_next = head_null;
                        end
                        else
                        begin
                            // untouched slots chain in index order
                            if (free_head_reg == wm_reg)
                            begin
                                next_free = free_head_reg + LW'(1);
                                wm_next   = wm_reg + LW'(1);
                            end
                            link_we                = 1'b1;
                            link_waddr             = IW'(free_head_reg);
                            link_wdata             = head_eff;
                            head_we                = 1'b1;
                            head_wdata             = free_head_reg;
                            head_vld_next[cur_sid] = 1'b1;
                            value_we               = 1'b1;
                            free_head_next         = next_free;
                            pool_full_next         = (next_free >= LINK_NULL);
                            stack_empty_next       = 1'b0;
                        end
                    end
                    CMD_POP:
                    begin
                        if (head_null)
                        begin
                            status_next = ST_UNDERFLOW;
                        end
                        else
                        begin
                            link_we          = 1'b1;
                            link_waddr       = IW'(head_eff);
                            link_wdata       = free_head_reg;
                            head_we          = 1'b1;
                            head_wdata       = link_rd_reg;
                            free_head_next   = head_eff;
                            pop_value_next   = value_rd_reg;
                            pool_full_next   = 1'b0;
                            stack_empty_next = (link_rd_reg >= LINK_NULL);
                        end
                    end
                    CMD_PUSH_REJECT:
                    begin
                        status_next = ST_OVERFLOW;
                    end
                    CMD_POP_REJECT:
                    begin
                        status_next = ST_UNDERFLOW;
                    end
                    default:
                    begin
                        status_next = ST_UNDERFLOW;
                    end
                endcase
            end
            default:
            begin
                state_next = BS_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= BS_IDLE;
            free_head_reg   <= '0;
            wm_reg          <= '0;
            head_vld_reg    <= '0;
            head_rd_vld_reg <= 1'b0;
            done_reg        <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            free_head_reg <= free_head_next;
            wm_reg        <= wm_next;
            head_vld_reg  <= head_vld_next;
            done_reg      <= done_next;
            if (in_take)
            begin
                head_rd_vld_reg <= head_vld_reg[head_raddr];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        if (state_reg == BS_EXEC)
        begin
            pop_value_reg   <= pop_value_next;
            status_reg      <= status_next;
            pool_full_reg   <= pool_full_next;
            stack_empty_reg <= stack_empty_next;
        end
    end

    // stack head memory
    always_ff @(posedge clk)
    begin
        if (head_we)
        begin
            heads_mem[cur_sid] <= head_wdata;
        end
        if (in_take)
        begin
            head_rd_reg <= heads_mem[head_raddr];
        end
    end

    // link memory
    always_ff @(posedge clk)
    begin
        if (link_we)
        begin
            links_mem[link_waddr] <= link_wdata;
        end
        link_rd_reg <= links_mem[link_raddr];
    end

    // value memory
    always_ff @(posedge clk)
    begin
        if (value_we)
        begin
            values_mem[IW'(free_head_reg)] <= cur_reg.value;
        end
        value_rd_reg <= values_mem[value_raddr];
    end

    assign done        = done_reg;
    assign pop_value   = pop_value_reg;
    assign status      = status_reg;
    assign pool_full   = pool_full_reg;
    assign stack_empty = stack_empty_reg;

endmodule

// ===== rtl/shared_buffer_multi_stack.sv =====
// Top level of the shared-buffer multi-stack: front, queue and back parts.
// Depends on sbms_pkg, sbms_front, sbms_queue and sbms_back.
`timescale 1ns / 1ps

// NUM_STACKS LIFO stacks share one pool of NUM_SLOTS value slots.
// Command channel: a beat (operation, stack_id, push_value) is taken at a
//   rising edge with start high and busy low. busy rises only when the
//   front register and the two-entry queue behind it are all occupied.
// Result channel: done is high for exactly one cycle with pop_value,
//   status, pool_full and stack_empty; one result per command, in order.
//   The receiver cannot stall, so results never wait.
// Back part: takes a new command only when idle; a push or a rejected
//   command then executes, while a pop first reads the head, then the link
//   and value, then writes back, since its memories have registered reads.
// Reset: the free list starts at slot 0, every stack empty. Link memory
//   needs no clearing pass; a watermark marks slots never taken, which
//   chain in index order. Slot values are undefined until written.
module shared_buffer_multi_stack #(
    parameter int NUM_STACKS = 4,
    parameter int NUM_SLOTS  = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                operation,
    input  logic [sbms_pkg::SID_W-1:0]          stack_id,
    input  logic signed [sbms_pkg::VALUE_W-1:0] push_value,
    output logic                                done,
    output logic signed [sbms_pkg::VALUE_W-1:0] pop_value,
    output logic [1:0]                          status,
    output logic                                pool_full,
    output logic                                stack_empty
);
    import sbms_pkg::*;

    beat_t front_beat;   // classified command waiting for the queue
    beat_t queue_beat;   // oldest queued command
    logic  queue_ready;
    logic  back_take;

    // classification: bad stack ids become reject commands here
    sbms_front #(
        .NUM_STACKS (NUM_STACKS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .operation  (operation),
        .stack_id   (stack_id),
        .push_value (push_value),
        .out_beat   (front_beat),
        .out_ready  (queue_ready)
    );

    sbms_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_beat  (front_beat),
        .in_ready (queue_ready),
        .out_beat (queue_beat),
        .out_take (back_take)
    );

    // execution: free list, links, heads and values
    sbms_back #(
        .NUM_STACKS (NUM_STACKS),
        .NUM_SLOTS  (NUM_SLOTS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_beat     (queue_beat),
        .in_take     (back_take),
        .done        (done),
        .pop_value   (pop_value),
        .status      (status),
        .pool_full   (pool_full),
        .stack_empty (stack_empty)
    );

endmodule

// ===== rtl/sbms_checker.sv =====
// Port-level checker for shared_buffer_multi_stack and its bind statement.
// Depends on sbms_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sbms_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input logic [31:0] pop_value,
    input logic [1:0]  status,
    input logic        pool_full,
    input logic        stack_empty
);
    import sbms_pkg::*;

    `SBMS_ASSERT_SAME(a_underflow_clean, done && status == ST_UNDERFLOW, pop_value == '0 && stack_empty, "underflow result must carry zero data and an empty stack")
    `SBMS_ASSERT_SAME(a_overflow_cause, done && status == ST_OVERFLOW && !stack_empty, pool_full, "overflow on a live stack without a full pool")
    `SBMS_ASSERT_SAME(a_full_after_push, done && status == ST_DONE && pool_full, !stack_empty, "pool full after a successful step but stack reported empty")
    `SBMS_ASSERT_NEXT(a_result_spacing, done, !done, "two result beats in consecutive cycles")

endmodule

bind shared_buffer_multi_stack sbms_checker u_sbms_checker (.*);
